// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define USSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usss check failed");

// Next-cycle implication, checked out of reset.
`define USSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usss check failed");

`endif

// ===== rtl/usss_pkg.sv =====
package usss_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int DIGIT_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [7:0] seg_t;
    typedef seg_t [NUM_DIGITS-1:0] seg_store_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [15:0]        word;
        logic [7:0]         pwm;
    } frame_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUILD_TAG = 1'b0,
        CFG_MSB_FIRST = 1'b1
    } cfg_idx_t;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    localparam logic [3:0]  BC_BRIGHT_LO = 4'd8;
    localparam logic [3:0]  BC_BRIGHT_HI = 4'd9;
    localparam logic [3:0]  BC_DONE      = 4'd10;
    localparam logic [7:0]  IDLE_LIMIT   = 8'd2;
    localparam logic [7:0]  IDLE_MAX     = 8'hff;
    localparam logic [15:0] UPTIME_MAX   = 16'hffff;
    localparam logic [15:0] HELLO_TICK   = 16'd1000;
    localparam logic [15:0] TAG_TICK     = 16'd2000;

    localparam logic [15:0] BRIGHT_RESET = 16'he4e4;
    localparam logic [15:0] HELLO_BRIGHT = 16'h1554;
    localparam logic [15:0] TAG_BRIGHT   = 16'haa55;
    localparam seg_t        SEG_BLANK    = 8'hff;

    localparam seg_t HEX_GLYPH [16] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0,
        8'hfe, 8'hf6, 8'hee, 8'h3e, 8'h9c, 8'h7a, 8'h9e, 8'h8e
    };
    localparam seg_t HELLO_GLYPH [NUM_DIGITS] = '{
        8'h02, 8'h6e, 8'h9e, 8'h1c, 8'h1c, 8'hfc, 8'h41, 8'h02
    };
    localparam seg_t TAG_GLYPH [4] = '{8'h6e, 8'hee, 8'hb6, 8'h6f};
    localparam logic [7:0] PWM_TABLE [4] = '{8'd252, 8'd224, 8'd148, 8'd0};

endpackage

// ===== rtl/usss_in_if.sv =====
interface usss_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// ===== rtl/usss_out_if.sv =====
interface usss_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  echo_byte;
    logic [2:0]  digit_index;
    logic [15:0] shift_word;
    logic [7:0]  pwm_compare;

    modport source (output valid, output kind, output echo_byte, output digit_index,
                    output shift_word, output pwm_compare, input ready);
    modport sink (input valid, input kind, input echo_byte, input digit_index,
                  input shift_word, input pwm_compare, output ready);
endinterface

// ===== rtl/usss_cfg_if.sv =====
interface usss_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/usss_frame_gen.sv =====
module usss_frame_gen
    import usss_pkg::*;
(
    input  seg_store_t         store,
    input  logic [15:0]        brightness,
    input  logic [DIGIT_W-1:0] digit,
    input  logic               msb_first,
    output frame_t             frame
);

    logic [15:0] raw_word;
    logic [7:0]  select_n;
    logic [1:0]  level;

    always_comb
    begin
        // Active-low select: bit (7 - digit) low.
        select_n = 8'hff ^ (8'h80 >> digit);
        raw_word = {store[digit], select_n};
        level    = brightness[{digit, 1'b0} +: 2];

        frame.digit = digit;
        frame.pwm   = PWM_TABLE[level];
        for (int k = 0; k < 16; k++)
        begin
            frame.word[k] = msb_first ? raw_word[15 - k] : raw_word[k];
        end
    end

endmodule

// ===== rtl/uart_seven_segment_scanner_unit.sv =====
// Eight-digit seven-segment scanner with a UART byte front end. One item is taken per
// clock: a received byte fills the segment store, then the brightness word, and after
// that is echoed; a scan tick returns the shift word and PWM compare for the current
// digit. A result appears in the output register the cycle after its item is accepted,
// and a byte that only updates state gives none. The input is ready whenever the output
// register is empty or being taken in the same cycle, so with the sink always ready the
// block sustains one item per cycle. Configuration writes are always taken.
`include "assert_macros.svh"

module uart_seven_segment_scanner_unit
    import usss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    usss_in_if.sink    item,
    usss_out_if.source result,
    usss_cfg_if.sink   cfg
);

    seg_store_t         store_reg, store_next;
    logic [15:0]        bright_reg, bright_next;
    logic [3:0]         count_reg, count_next;
    logic [7:0]         idle_reg, idle_next;
    logic [15:0]        uptime_reg, uptime_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic [15:0]        tag_reg;
    logic               msb_first_reg;

    logic               out_valid_reg, out_valid_next;
    logic               kind_reg, kind_next;
    logic [7:0]         echo_reg, echo_next;
    frame_t             frame_reg, frame_next;

    frame_t             frame;
    logic               in_fire;
    logic               emit;
    logic [3:0]         count_eff;

    usss_frame_gen u_frame_gen (
        .store      (store_reg),
        .brightness (bright_reg),
        .digit      (digit_reg),
        .msb_first  (msb_first_reg),
        .frame      (frame)
    );

    assign item.ready = !out_valid_reg || result.ready;
    assign in_fire    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        store_next     = store_reg;
        bright_next    = bright_reg;
        count_next     = count_reg;
        idle_next      = idle_reg;
        uptime_next    = uptime_reg;
        digit_next     = digit_reg;
        kind_next      = kind_reg;
        echo_next      = echo_reg;
        frame_next     = frame_reg;
        emit           = 1'b0;
        count_eff      = (idle_reg > IDLE_LIMIT) ? 4'd0 : count_reg;

        if (in_fire && item.func == FUNC_BYTE)
        begin
            idle_next   = 8'd0;
            uptime_next = UPTIME_MAX;
            count_next  = count_eff;
            if (count_eff < BC_BRIGHT_LO)
            begin
                store_next[count_eff[DIGIT_W-1:0]] = item.rx_byte;
                count_next = count_eff + 4'd1;
            end
            else if (count_eff == BC_BRIGHT_LO)
            begin
                bright_next[7:0] = item.rx_byte;
                count_next = count_eff + 4'd1;
            end
            else if (count_eff == BC_BRIGHT_HI)
            begin
                bright_next[15:8] = item.rx_byte;
                count_next = count_eff + 4'd1;
            end
            else
            begin
                emit       = 1'b1;
                kind_next  = KIND_ECHO;
                echo_next  = item.rx_byte;
                frame_next = '0;
            end
        end
        else if (in_fire)
        begin
            emit       = 1'b1;
            kind_next  = KIND_SCAN;
            echo_next  = 8'd0;
            frame_next = frame;
            // Splash screens run only until the first byte pins uptime at max.
            if (uptime_reg == HELLO_TICK)
            begin
                for (int k = 0; k < NUM_DIGITS; k++)
                begin
                    store_next[k] = HELLO_GLYPH[k];
                end
                bright_next = HELLO_BRIGHT;
            end
            if (uptime_reg == TAG_TICK)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    store_next[k]     = TAG_GLYPH[k];
                    store_next[k + 4] = HEX_GLYPH[tag_reg[(3 - k) * 4 +: 4]];
                end
                bright_next = TAG_BRIGHT;
            end
            if (idle_reg != IDLE_MAX)
            begin
                idle_next = idle_reg + 8'd1;
            end
            if (uptime_reg != UPTIME_MAX)
            begin
                uptime_next = uptime_reg + 16'd1;
            end
            digit_next = digit_reg + 3'd1;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                store_reg[k] <= SEG_BLANK;
            end
            bright_reg    <= BRIGHT_RESET;
            count_reg     <= 4'd0;
            idle_reg      <= 8'd0;
            uptime_reg    <= 16'd0;
            digit_reg     <= '0;
            tag_reg       <= 16'd0;
            msb_first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            store_reg     <= store_next;
            bright_reg    <= bright_next;
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            uptime_reg    <= uptime_next;
            digit_reg     <= digit_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_BUILD_TAG: tag_reg       <= cfg.data;
                    CFG_MSB_FIRST: msb_first_reg <= cfg.data[0];
                    default:       tag_reg       <= tag_reg;
                endcase
            end
        end
    end

    // Result payload, loaded only with a new beat.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        echo_reg  <= echo_next;
        frame_reg <= frame_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = kind_reg;
    assign result.echo_byte   = echo_reg;
    assign result.digit_index = frame_reg.digit;
    assign result.shift_word  = frame_reg.word;
    assign result.pwm_compare = frame_reg.pwm;

    `USSS_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= BC_DONE)
    `USSS_ASSERT_NEXT(a_tick_emits, clk, rst_n, in_fire && item.func == FUNC_TICK,
        out_valid_reg && kind_reg == KIND_SCAN)
    `USSS_ASSERT_NEXT(a_digit_step, clk, rst_n, in_fire && item.func == FUNC_TICK,
        digit_reg == $past(digit_reg) + 3'd1)
    `USSS_ASSERT_NEXT(a_byte_stops_splash, clk, rst_n, in_fire && item.func == FUNC_BYTE,
        uptime_reg == UPTIME_MAX && idle_reg == 8'd0)

endmodule
